// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/ssig_pkg.sv =====
package ssig_pkg;

    // Size limits of the sphere.
    localparam int MAX_SLICES = 256;
    localparam int MAX_RINGS  = 256;
    localparam int MIN_RINGS  = 4;

    // Field and state widths.
    localparam int SLICE_W   = 9;
    localparam int RING_W    = 9;
    localparam int ROW_W     = 8;
    localparam int SLOT_W    = 10;
    localparam int IDX_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURED_MODE = 2'd2;

    // Reset values of the configuration.
    localparam logic [SLICE_W-1:0] RST_SLICES   = 9'd16;
    localparam logic [RING_W-1:0]  RST_RINGS    = 9'd16;
    localparam logic               RST_TEXTURED = 1'b1;

    // Position within the strip: ring pair and slot inside its run.
    typedef struct packed {
        logic [ROW_W-1:0]  ring_row;
        logic [SLOT_W-1:0] slot;
    } t_pos;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [SLICE_W-1:0] slices;
        logic [RING_W-1:0]  rings;
        logic               textured;
    } t_cfg;

endpackage

// ===== sv/sphere_strip_index_generator_top.sv =====
// An accepted request's index goes to the output register, or to the skid entry while it is held.
// Throughput: one request per cycle while the input is not stalled; the strip position
// registers advance on every request. The skid entry takes one more request after the output
// stalls; the input then stalls until the output moves. Configuration writes are always ready.
// Reset (synchronous, active low): 16 slices, 16 rings, textured mode, position at strip start,
// output empty.
`include "assert_macros.svh"

module sphere_strip_index_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssig_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssig_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // Request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_restart,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ssig_pkg::IDX_W-1:0]        o_vertex_index,
    output logic                              o_strip_last
);

    ssig_pkg::t_cfg                r_cfg;
    ssig_pkg::t_pos                r_pos;
    ssig_pkg::t_pos                n_pos;
    logic [ssig_pkg::IDX_W-1:0]    r_prev_index;
    logic [ssig_pkg::IDX_W-1:0]    n_index;
    logic                          n_last;
    logic                          r_out_valid, r_out_last;
    logic [ssig_pkg::IDX_W-1:0]    r_out_index;
    logic                          r_skid_valid, r_skid_last;
    logic [ssig_pkg::IDX_W-1:0]    r_skid_index;
    logic                          in_accept, out_pop;
    logic [ssig_pkg::SLICE_W-1:0]  cfg_slices;
    logic [ssig_pkg::RING_W-1:0]   cfg_rings;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_pop     = r_out_valid && !i_out_stall;

    // Clamp written sizes into the supported range.
    always_comb begin
        priority if (i_cfg_data == '0) begin
            cfg_slices = ssig_pkg::SLICE_W'(1);
        end else if (i_cfg_data > ssig_pkg::CFG_DAT_W'(ssig_pkg::MAX_SLICES)) begin
            cfg_slices = ssig_pkg::SLICE_W'(ssig_pkg::MAX_SLICES);
        end else begin
            cfg_slices = ssig_pkg::SLICE_W'(i_cfg_data);
        end
        priority if (i_cfg_data < ssig_pkg::CFG_DAT_W'(ssig_pkg::MIN_RINGS)) begin
            cfg_rings = ssig_pkg::RING_W'(ssig_pkg::MIN_RINGS);
        end else if (i_cfg_data > ssig_pkg::CFG_DAT_W'(ssig_pkg::MAX_RINGS)) begin
            cfg_rings = ssig_pkg::RING_W'(ssig_pkg::MAX_RINGS);
        end else begin
            cfg_rings = ssig_pkg::RING_W'(i_cfg_data);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slices   <= ssig_pkg::RST_SLICES;
            r_cfg.rings    <= ssig_pkg::RST_RINGS;
            r_cfg.textured <= ssig_pkg::RST_TEXTURED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ssig_pkg::CFG_SLICE_COUNT:   r_cfg.slices   <= cfg_slices;
                ssig_pkg::CFG_RING_COUNT:    r_cfg.rings    <= cfg_rings;
                ssig_pkg::CFG_TEXTURED_MODE: r_cfg.textured <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Index computation for the current position.
    ssig_index_calc u_calc (
        .i_cfg          (r_cfg),
        .i_pos          (r_pos),
        .i_prev_index   (r_prev_index),
        .i_restart      (i_restart),
        .o_vertex_index (n_index),
        .o_strip_last   (n_last),
        .o_next_pos     (n_pos)
    );

    // Strip position and last emitted index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_prev_index <= '0;
        end else if (in_accept) begin
            r_pos        <= n_pos;
            r_prev_index <= n_index;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_pop) begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid) begin
            r_skid_valid <= r_skid_valid || in_accept;
        end else begin
            r_out_valid  <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop && r_skid_valid) begin
            r_out_index <= r_skid_index;
            r_out_last  <= r_skid_last;
        end else if (in_accept && (out_pop || !r_out_valid)) begin
            r_out_index <= n_index;
            r_out_last  <= n_last;
        end
        if (in_accept && r_out_valid && !out_pop) begin
            r_skid_index <= n_index;
            r_skid_last  <= n_last;
        end
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = r_out_index;
    assign o_strip_last   = r_out_last;

    // The skid entry is only ever filled behind a full output register.
    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // The strip wraps to its start right after the final index.
    `ASSERT_NEXT(a_last_wraps, i_clk, i_rst_n, in_accept && n_last, r_pos == '0)
    // A restarted strip moves on to the second slot of the first ring pair.
    `ASSERT_IMPLIES(a_restart_first, i_clk, i_rst_n, in_accept && i_restart, n_pos.ring_row == '0 && n_pos.slot == ssig_pkg::SLOT_W'(1))

endmodule

// ===== sv/ssig_index_calc.sv =====
module ssig_index_calc (
    input  ssig_pkg::t_cfg                 i_cfg,
    input  ssig_pkg::t_pos                 i_pos,
    input  logic [ssig_pkg::IDX_W-1:0]     i_prev_index,
    input  logic                           i_restart,
    output logic [ssig_pkg::IDX_W-1:0]     o_vertex_index,
    output logic                           o_strip_last,
    output ssig_pkg::t_pos                 o_next_pos
);

    // Which vertex of a column or gap is produced.
    localparam logic [1:0] SEL_LOWER = 2'd0;
    localparam logic [1:0] SEL_UPPER = 2'd1;
    localparam logic [1:0] SEL_DEGEN = 2'd2;

    localparam int PROD_W = ssig_pkg::RING_W + ssig_pkg::SLICE_W;

    logic [ssig_pkg::ROW_W-1:0]   j0, j;
    logic [ssig_pkg::SLOT_W-1:0]  k0, k, k1;
    logic [ssig_pkg::SLOT_W-1:0]  pairs_len, row_len0, row_len;
    logic [ssig_pkg::RING_W-1:0]  jx0, jx, l;
    logic [ssig_pkg::SLICE_W-1:0] s, col, n, factor;
    logic                         last_row0, last_row, wrap;
    logic                         is_pair, is_repeat;
    logic [1:0]                   sel;
    logic [ssig_pkg::RING_W-1:0]  row;
    logic [PROD_W-1:0]            prod;
    logic [ssig_pkg::IDX_W-1:0]   addend, sum;

    assign s = i_cfg.slices;
    assign l = i_cfg.rings;
    assign pairs_len = {s, 1'b0} + ssig_pkg::SLOT_W'(2);

    // Restart, then fall back to the strip start if the held position lies outside it.
    assign j0        = i_restart ? '0 : i_pos.ring_row;
    assign k0        = i_restart ? '0 : i_pos.slot;
    assign jx0       = ssig_pkg::RING_W'(j0);
    assign last_row0 = (jx0 + ssig_pkg::RING_W'(2)) == l;
    assign row_len0  = pairs_len + (last_row0 ? ssig_pkg::SLOT_W'(0) : ssig_pkg::SLOT_W'(2));
    assign wrap      = ((jx0 + ssig_pkg::RING_W'(1)) >= l) || (k0 >= row_len0);
    assign j         = wrap ? '0 : j0;
    assign k         = wrap ? '0 : k0;
    assign jx        = ssig_pkg::RING_W'(j);
    assign last_row  = (jx + ssig_pkg::RING_W'(2)) == l;
    assign row_len   = pairs_len + (last_row ? ssig_pkg::SLOT_W'(0) : ssig_pkg::SLOT_W'(2));

    // Slot decode: column pairs, then the repeat, then the next pair's first vertex.
    assign col       = k[ssig_pkg::SLOT_W-1:1];
    assign is_pair   = k < pairs_len;
    assign is_repeat = k == pairs_len;
    assign sel       = is_pair ? (k[0] ? SEL_LOWER : SEL_UPPER) : SEL_DEGEN;
    assign n         = (col == s) ? '0 : col;

    // One shared multiply gives the ring base for the lower, upper and degenerate vertices.
    assign row    = jx + ssig_pkg::RING_W'(sel)
                  - (i_cfg.textured ? ssig_pkg::RING_W'(0) : ssig_pkg::RING_W'(1));
    assign factor = i_cfg.textured ? (s + ssig_pkg::SLICE_W'(1)) : s;
    assign prod   = PROD_W'(row) * PROD_W'(factor);

    always_comb begin
        if (i_cfg.textured) begin
            addend = (sel == SEL_DEGEN) ? '0 : ssig_pkg::IDX_W'(col);
        end else begin
            addend = ssig_pkg::IDX_W'(2)
                   + ((sel == SEL_DEGEN) ? ssig_pkg::IDX_W'(0) : ssig_pkg::IDX_W'(n));
        end
    end

    assign sum = prod[ssig_pkg::IDX_W-1:0] + addend;

    // Final index selection: the repeated index, the shared pole vertices of the untextured mesh, or the sum.
    always_comb begin
        priority if (is_repeat) begin
            o_vertex_index = i_prev_index;
        end else if (!i_cfg.textured && sel == SEL_UPPER && last_row) begin
            o_vertex_index = ssig_pkg::IDX_W'(1);
        end else if (!i_cfg.textured && sel == SEL_LOWER && j == '0) begin
            o_vertex_index = '0;
        end else if (!i_cfg.textured && sel == SEL_DEGEN
                     && (jx + ssig_pkg::RING_W'(3)) == l) begin
            o_vertex_index = ssig_pkg::IDX_W'(1);
        end else begin
            o_vertex_index = sum;
        end
    end

    // Position advance.
    assign k1           = k + ssig_pkg::SLOT_W'(1);
    assign o_strip_last = last_row && (k1 == pairs_len);

    always_comb begin
        priority if (o_strip_last) begin
            o_next_pos.ring_row = '0;
            o_next_pos.slot     = '0;
        end else if (k1 >= row_len) begin
            o_next_pos.ring_row = j + ssig_pkg::ROW_W'(1);
            o_next_pos.slot     = '0;
        end else begin
            o_next_pos.ring_row = j;
            o_next_pos.slot     = k1;
        end
    end

endmodule

// ===== test/tb_sphere_strip_index_generator_top.sv =====
`timescale 1ns / 1ps

module tb_sphere_strip_index_generator_top;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 64;
    localparam int DIRECTED_ROWS  = 28;
    // With one slice, every ring pair except the last takes six requests.
    localparam int THIN_ROW_LEN   = 6;
    localparam int THIN_RINGS     = 48;
    localparam int WIDE_SLICES    = 64;
    localparam logic [ssig_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One index of the strip as it leaves the block.
    typedef struct packed {
        logic [ssig_pkg::IDX_W-1:0] vertex_index;
        logic                       strip_last;
    } t_strip_out;

    typedef enum logic { ROW_REQUEST, ROW_SETTING } t_row_kind;
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;

    // One line of the directed table: either a register write or a request.
    typedef struct packed {
        t_row_kind                          kind;
        logic [ssig_pkg::CFG_IDX_W-1:0]     cfg_index;
        logic [ssig_pkg::CFG_DAT_W-1:0]     cfg_data;
        logic                               restart;
        logic                               typed;
        t_strip_out                         typed_out;
    } t_stim_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [ssig_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [ssig_pkg::CFG_DAT_W-1:0]     i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic                               i_restart;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic [ssig_pkg::IDX_W-1:0]         o_vertex_index;
    logic                               o_strip_last;

    // Shadow copy of the block's configuration and strip position.
    logic [ssig_pkg::SLICE_W-1:0]       cfg_slices;
    logic [ssig_pkg::RING_W-1:0]        cfg_rings;
    logic                               cfg_textured;
    ssig_pkg::t_pos                     strip_pos;
    logic [ssig_pkg::IDX_W-1:0]         last_index;

    t_strip_out             pending_indices[$];
    t_idle_mode             idle_mode = IDLE_NONE;
    int                     fail_count = 0;
    int                     cycle_count = 0;

    // Request rows use the unused register index as filler.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b1, '{17'd17, 1'b0}},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b1, '{17'd0, 1'b0}},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b1, 1'b1, '{17'd17, 1'b0}},
        '{ROW_SETTING, ssig_pkg::CFG_SLICE_COUNT, 9'h000, 1'b0, 1'b0, '0},
        '{ROW_SETTING, ssig_pkg::CFG_RING_COUNT, 9'h000, 1'b0, 1'b0, '0},
        '{ROW_SETTING, ssig_pkg::CFG_TEXTURED_MODE, 9'h1FE, 1'b0, 1'b0, '0},
        '{ROW_SETTING, CFG_UNUSED, 9'h1FF, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b1, 1'b1, '{17'd2, 1'b0}},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b0, '0},
        '{ROW_SETTING, ssig_pkg::CFG_TEXTURED_MODE, 9'h001, 1'b0, 1'b0, '0},
        '{ROW_SETTING, ssig_pkg::CFG_RING_COUNT, 9'h1FF, 1'b0, 1'b0, '0},
        '{ROW_SETTING, ssig_pkg::CFG_SLICE_COUNT, 9'h1FF, 1'b0, 1'b0, '0},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b1, 1'b1, '{17'd257, 1'b0}},
        '{ROW_REQUEST, CFG_UNUSED, 9'd0, 1'b0, 1'b1, '{17'd0, 1'b0}}
    };

    sphere_strip_index_generator_top dut (.*);

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Computes the next strip index and advances the shadow position.
    function automatic t_strip_out next_strip_index(input logic restart);
        int         s;
        int         l;
        int         pairs_len;
        int         row_len;
        int         j;
        int         k;
        int         col;
        int         n;
        int         idx;
        bit         last_row;
        t_strip_out res;
        s = (cfg_slices == 0) ? 1
            : ((cfg_slices > ssig_pkg::MAX_SLICES) ? ssig_pkg::MAX_SLICES : int'(cfg_slices));
        l = (cfg_rings < ssig_pkg::MIN_RINGS) ? ssig_pkg::MIN_RINGS
            : ((cfg_rings > ssig_pkg::MAX_RINGS) ? ssig_pkg::MAX_RINGS : int'(cfg_rings));
        pairs_len = 2 + 2 * s;
        if (restart) begin
            strip_pos = '0;
        end
        j = strip_pos.ring_row;
        last_row = (j + 2 == l);
        row_len = pairs_len + (last_row ? 0 : 2);
        // A position left outside the strip by a new setting wraps to the start.
        if (j + 1 >= l || strip_pos.slot >= row_len) begin
            strip_pos = '0;
            j = 0;
            last_row = (j + 2 == l);
            row_len = pairs_len + (last_row ? 0 : 2);
        end
        k = strip_pos.slot;
        // Upper and lower vertex per column, then the two degenerate indices.
        if (k < pairs_len) begin
            col = k >> 1;
            if (cfg_textured) begin
                idx = col + (((k % 2) == 0) ? j + 1 : j) * (s + 1);
            end else begin
                n = (col == s) ? 0 : col;
                if ((k % 2) == 0) begin
                    idx = (j + 2 == l) ? 1 : 2 + n + j * s;
                end else begin
                    idx = (j == 0) ? 0 : 2 + n + (j - 1) * s;
                end
            end
        end else if (k == pairs_len) begin
            idx = last_index;
        end else if (cfg_textured) begin
            idx = (j + 2) * (s + 1);
        end else begin
            idx = (j + 3 == l) ? 1 : 2 + (j + 1) * s;
        end
        res.vertex_index = idx[ssig_pkg::IDX_W-1:0];
        res.strip_last = last_row && (k + 1 == pairs_len);
        if (k + 1 >= row_len) begin
            strip_pos.slot = '0;
            strip_pos.ring_row = ssig_pkg::ROW_W'(j + 1);
        end else begin
            strip_pos.slot = ssig_pkg::SLOT_W'(k + 1);
        end
        if (res.strip_last) begin
            strip_pos = '0;
        end
        last_index = res.vertex_index;
        return res;
    endfunction

    // Picks a size register value: mostly small, sometimes out of range or large.
    function automatic logic [ssig_pkg::CFG_DAT_W-1:0] random_size(input int typical_hi,
                                                                   input int min_legal,
                                                                   input int max_legal);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
            return ssig_pkg::CFG_DAT_W'($urandom_range(min_legal, typical_hi));
        end else if (roll == 7) begin
            return ssig_pkg::CFG_DAT_W'($urandom_range(0, min_legal - 1));
        end else if (roll == 8) begin
            return ssig_pkg::CFG_DAT_W'($urandom_range(max_legal + 1,
                                                       (1 << ssig_pkg::CFG_DAT_W) - 1));
        end
        return ssig_pkg::CFG_DAT_W'($urandom_range(typical_hi + 1, max_legal));
    endfunction

    // Drives one request, holding it while stalled, and records its expected index.
    task automatic push_request(input logic restart, input logic typed,
                                input t_strip_out typed_out);
        int         gap_pct;
        t_strip_out predicted;
        gap_pct = (idle_mode == IDLE_SENDER) ? 66 : ((idle_mode == IDLE_BOTH) ? 33 : 0);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predicted = next_strip_index(restart);
        pending_indices.push_back(typed ? typed_out : predicted);
    endtask

    task automatic pause_requests();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_all_indices();
        while (pending_indices.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Register writes happen only once the block has delivered every index.
    task automatic write_setting(input logic [ssig_pkg::CFG_IDX_W-1:0] index,
                                 input logic [ssig_pkg::CFG_DAT_W-1:0] data);
        pause_requests();
        wait_all_indices();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        unique case (index)
            ssig_pkg::CFG_SLICE_COUNT: begin
                cfg_slices = data;
            end
            ssig_pkg::CFG_RING_COUNT: begin
                cfg_rings = data;
            end
            ssig_pkg::CFG_TEXTURED_MODE: begin
                cfg_textured = data[0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The result side stalls at random according to the current idle mode.
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: begin
                i_out_stall <= ($urandom_range(0, 99) < 66);
            end
            IDLE_BOTH: begin
                i_out_stall <= ($urandom_range(0, 99) < 33);
            end
            default: begin
                i_out_stall <= 1'b0;
            end
        endcase
    end

    // Each delivered index is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_index
        t_strip_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_indices.size() == 0) begin
                $error("vertex_index %0d delivered with no request pending", o_vertex_index);
                fail_count++;
            end else begin
                want = pending_indices.pop_front();
                if (o_vertex_index !== want.vertex_index) begin
                    $error("vertex_index: expected %0d, got %0d",
                           want.vertex_index, o_vertex_index);
                    fail_count++;
                end
                if (o_strip_last !== want.strip_last) begin
                    $error("strip_last: expected %0d, got %0d", want.strip_last, o_strip_last);
                    fail_count++;
                end
            end
        end
    end

    // Guards against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_restart = 1'b0;
        i_out_stall = 1'b0;
        cfg_slices = ssig_pkg::RST_SLICES;
        cfg_rings = ssig_pkg::RST_RINGS;
        cfg_textured = ssig_pkg::RST_TEXTURED;
        strip_pos = '0;
        last_index = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset values, clamped sizes, both modes, restart.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_SETTING) begin
                write_setting(directed_rows[r].cfg_index, directed_rows[r].cfg_data);
            end else begin
                push_request(directed_rows[r].restart, directed_rows[r].typed,
                             directed_rows[r].typed_out);
            end
        end

        // Walk a thin sphere up to the last ring pair, then widen it mid-strip
        // so a wide last ring pair and the strip end appear.
        idle_mode = IDLE_BOTH;
        write_setting(ssig_pkg::CFG_SLICE_COUNT, 9'd1);
        write_setting(ssig_pkg::CFG_RING_COUNT, ssig_pkg::CFG_DAT_W'(THIN_RINGS));
        write_setting(ssig_pkg::CFG_TEXTURED_MODE, 9'd1);
        push_request(1'b1, 1'b0, '0);
        repeat ((THIN_RINGS - 2) * THIN_ROW_LEN - 1) push_request(1'b0, 1'b0, '0);
        write_setting(ssig_pkg::CFG_SLICE_COUNT, ssig_pkg::CFG_DAT_W'(WIDE_SLICES));
        repeat (2 * WIDE_SLICES + 2) push_request(1'b0, 1'b0, '0);

        // Random phases; settings change between phases without a restart.
        for (phase = 0; phase < PHASES; phase++) begin
            idle_mode = t_idle_mode'(phase % 4);
            write_setting(ssig_pkg::CFG_SLICE_COUNT,
                          random_size(4, 1, ssig_pkg::MAX_SLICES));
            write_setting(ssig_pkg::CFG_RING_COUNT,
                          random_size(7, ssig_pkg::MIN_RINGS, ssig_pkg::MAX_RINGS));
            write_setting(ssig_pkg::CFG_TEXTURED_MODE,
                          ssig_pkg::CFG_DAT_W'($urandom_range(0, 511)));
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                // Once, the sender holds off until the block has drained.
                if (phase == 1 && n == PHASE_REQUESTS / 2) begin
                    pause_requests();
                    wait_all_indices();
                end
                push_request($urandom_range(0, 29) == 0, 1'b0, '0);
            end
        end

        pause_requests();
        wait_all_indices();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
